@@ src/http_response_deframer_top_assert.svh @@
// Assertion macros for the deframer RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef HTTP_RESPONSE_DEFRAMER_TOP_ASSERT_SVH
`define HTTP_RESPONSE_DEFRAMER_TOP_ASSERT_SVH

// checked outside reset
`define HRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in reset too
`define HRD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/hrd_pkg.sv @@
// Shared types, constants and scan helpers of the HTTP response deframer.
// No dependencies.
package hrd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int CL_LEN = 14;
  localparam int TE_LEN = 17;
  localparam int CH_LEN = 7;
  localparam logic [8*CL_LEN-1:0] CL_NAME = "content-length";
  localparam logic [8*TE_LEN-1:0] TE_NAME = "transfer-encoding";
  localparam logic [8*CH_LEN-1:0] CH_WORD = "chunked";

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_C     = 8'h63;

  localparam logic [15:0] STATUS_MAX = 16'hffff;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [8:0] {
    PH_STATUS = 9'b000000001,
    PH_HDR0   = 9'b000000010,
    PH_HDR1   = 9'b000000100,
    PH_HDR    = 9'b000001000,
    PH_BODY   = 9'b000010000,
    PH_CSIZE  = 9'b000100000,
    PH_CDATA  = 9'b001000000,
    PH_CSKIP  = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_t;

  // number scan phase: 0 lead ws, 1 sign, 2 digits, 3 trail ws
  typedef struct packed {
    logic [1:0] ph;
    logic       neg;
    logic       bad;
  } scan_t;

  typedef struct packed {
    scan_t                  f;
    logic [LENGTH_BITS-1:0] acc;
  } num_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic        bad;
    logic [16:0] val;
  } stat_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  body_byte;
    logic        done_res;
    logic [16:0] status_code;
    logic        malformed;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] b);
    logic [4:0] d;
    if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h61) + 5'd10;
    else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h41) + 5'd10;
    else d = 5'd16;
    return d;
  endfunction

  function automatic logic [2:0] crlf_next(input logic [2:0] m, input logic [7:0] b);
    logic [2:0] r;
    if (b == CH_CR) r = (m == 3'd2) ? 3'd3 : 3'd1;
    else if (b == CH_LF) r = (m == 3'd1) ? 3'd2 : ((m == 3'd3) ? 3'd4 : 3'd0);
    else r = 3'd0;
    return r;
  endfunction

  function automatic num_t num_feed(input num_t s, input logic [7:0] b, input logic hex,
                                    input logic signs);
    num_t r;
    logic [4:0] d;
    logic [LENGTH_BITS+4:0] wide;
    r = s;
    d = digit_of(b);
    wide = hex ? {1'b0, s.acc, 4'b0000} : ({2'b00, s.acc, 3'b000} + {4'b0000, s.acc, 1'b0});
    wide = wide + {{LENGTH_BITS{1'b0}}, d};
    if (!s.f.bad) begin
      if (is_ws(b)) begin
        if (s.f.ph == 2'd1) r.f.bad = 1'b1;
        else if (s.f.ph == 2'd2) r.f.ph = 2'd3;
      end else if (signs && s.f.ph == 2'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
        if (b == CH_MINUS) r.f.neg = 1'b1;
        r.f.ph = 2'd1;
      end else if ((hex ? d[4] : (d > 5'd9)) || s.f.ph == 2'd3) begin
        r.f.bad = 1'b1;
      end else begin
        if (wide[LENGTH_BITS+4:LENGTH_BITS] != 5'd0) r.f.bad = 1'b1;
        else r.acc = wide[LENGTH_BITS-1:0];
        r.f.ph = 2'd2;
      end
    end
    return r;
  endfunction

  function automatic stat_t status_feed(input stat_t s, input logic [7:0] b);
    stat_t r;
    logic [19:0] v;
    r = s;
    v = {4'b0000, s.val[15:0]} * 20'd10 + {12'd0, b - 8'h30};
    if (b == CH_SP) begin
      if (s.cnt < 2'd2) r.cnt = s.cnt + 2'd1;
    end else if (s.cnt == 2'd1) begin
      if (b >= 8'h30 && b <= 8'h39)
        r.val = (v > {4'b0000, STATUS_MAX}) ? {1'b0, STATUS_MAX} : v[16:0];
      else
        r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos < 5'(CL_LEN)) ch = CL_NAME[8*(CL_LEN-1-int'(pos)) +: 8];
    return ch;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos < 5'(TE_LEN)) ch = TE_NAME[8*(TE_LEN-1-int'(pos)) +: 8];
    return ch;
  endfunction

  function automatic logic [7:0] ch_char(input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos < 3'(CH_LEN)) ch = CH_WORD[8*(CH_LEN-1-int'(pos)) +: 8];
    return ch;
  endfunction

endpackage

@@ src/hrd_front.sv @@
// Front end: accepts bytes, runs the status/header/body parse and forms result items.
// Depends on hrd_pkg.
module hrd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_cmd,
  input  logic [7:0]       in_byte,
  output logic             in_ready,
  input  logic             q_ready,
  output logic             push,
  output hrd_pkg::result_t push_data
);
  import hrd_pkg::*;

  phase_t                 phase, phase_next;
  logic [2:0]             crlf, crlf_next_v;
  stat_t                  st, st_next, st_tmp;
  logic [4:0]             npos, npos_next;
  logic [2:0]             hits, hits_next;
  num_t                   num, num_next, num_tmp;
  logic [2:0]             chpos, chpos_next;
  logic                   chunked, chunked_next;
  logic                   clv, clv_next;
  logic [LENGTH_BITS-1:0] cl, cl_next;
  logic [LENGTH_BITS-1:0] left, left_next;
  logic [1:0]             skip, skip_next, skip_tmp;
  logic [7:0]             c;
  result_t                res;
  logic                   res_v;
  logic                   accept;

  function automatic result_t fin_item(input logic has, input logic [7:0] bv,
                                       input logic bad, input logic [16:0] sv);
    result_t r;
    r.has_byte    = has;
    r.body_byte   = has ? bv : 8'd0;
    r.done_res    = 1'b1;
    r.status_code = bad ? 17'h1ffff : sv;
    r.malformed   = bad;
    return r;
  endfunction

  function automatic result_t emit_item(input logic [7:0] bv);
    result_t r;
    r = '0;
    r.has_byte  = 1'b1;
    r.body_byte = bv;
    return r;
  endfunction

  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign push      = accept && res_v;
  assign push_data = res;
  assign c         = to_lower(in_byte);

  always_comb begin
    phase_next   = phase;
    crlf_next_v  = crlf;
    st_next      = st;
    st_tmp       = st;
    npos_next    = npos;
    hits_next    = hits;
    num_next     = num;
    num_tmp      = num;
    chpos_next   = chpos;
    chunked_next = chunked;
    clv_next     = clv;
    cl_next      = cl;
    left_next    = left;
    skip_next    = skip;
    skip_tmp     = skip;
    res          = '0;
    res_v        = 1'b0;
    if (in_cmd) begin
      phase_next   = PH_STATUS;
      crlf_next_v  = 3'd0;
      st_next      = '0;
      npos_next    = 5'd0;
      hits_next    = 3'b011;
      num_next     = '0;
      chpos_next   = 3'd0;
      chunked_next = 1'b0;
      clv_next     = 1'b0;
      cl_next      = '0;
      left_next    = '0;
      skip_next    = 2'd0;
    end else begin
      unique case (phase)
        PH_STATUS: begin
          crlf_next_v = crlf_next(crlf, in_byte);
          if (crlf == 3'd1 && in_byte == CH_LF) begin
            phase_next = PH_HDR0;
            if (st.cnt == 2'd0) st_next.val = 17'h1ffff;
            else if (st.bad) st_next.val = 17'd0;
          end else begin
            st_tmp  = (crlf == 3'd1) ? status_feed(st, CH_CR) : st;
            st_next = (in_byte != CH_CR) ? status_feed(st_tmp, in_byte) : st_tmp;
          end
        end
        PH_HDR0, PH_HDR1, PH_HDR: begin
          crlf_next_v = crlf_next(crlf, in_byte);
          if (phase == PH_HDR1 && in_byte == CH_LF) begin
            res        = fin_item(1'b0, 8'd0, 1'b1, st.val);
            res_v      = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = (phase == PH_HDR0 && in_byte == CH_CR) ? PH_HDR1 : PH_HDR;
            if (in_byte == CH_LF) begin
              if (hits[2]) begin
                if (hits[0]) begin
                  if (num.f.bad || num.f.ph < 2'd2) begin
                    clv_next = 1'b1;
                    cl_next  = '0;
                  end else if (num.f.neg && num.acc != '0) begin
                    clv_next = 1'b0;
                  end else begin
                    clv_next = 1'b1;
                    cl_next  = num.acc;
                  end
                end else if (hits[1] && chpos == 3'(CH_LEN)) begin
                  chunked_next = 1'b1;
                end
              end
              npos_next  = 5'd0;
              hits_next  = 3'b011;
              num_next   = '0;
              chpos_next = 3'd0;
            end else if (!hits[2]) begin
              if (in_byte == CH_COLON || is_ws(in_byte)) begin
                if (in_byte == CH_COLON || npos != 5'd0) begin
                  if (npos != 5'(CL_LEN)) hits_next[0] = 1'b0;
                  if (npos != 5'(TE_LEN)) hits_next[1] = 1'b0;
                end
                if (in_byte == CH_COLON) hits_next[2] = 1'b1;
              end else begin
                if (npos >= 5'(CL_LEN) || c != cl_char(npos)) hits_next[0] = 1'b0;
                if (npos >= 5'(TE_LEN) || c != te_char(npos)) hits_next[1] = 1'b0;
                if (npos != 5'd31) npos_next = npos + 5'd1;
              end
            end else begin
              num_next = num_feed(num, in_byte, 1'b0, 1'b1);
              if (chpos < 3'(CH_LEN)) begin
                if (c == ch_char(chpos)) chpos_next = chpos + 3'd1;
                else chpos_next = (c == CH_C) ? 3'd1 : 3'd0;
              end
            end
            // header end sees this line's updates
            if (crlf_next_v == 3'd4) begin
              if (chunked_next) begin
                phase_next  = PH_CSIZE;
                crlf_next_v = 3'd0;
                num_next    = '0;
              end else if (clv_next && cl_next != '0) begin
                left_next  = cl_next;
                phase_next = PH_BODY;
              end else begin
                res        = fin_item(1'b0, 8'd0, 1'b0, st.val);
                res_v      = 1'b1;
                phase_next = PH_DONE;
              end
            end
          end
        end
        PH_BODY: begin
          left_next = left - 1'b1;
          res_v     = 1'b1;
          if (left_next == '0) begin
            res        = fin_item(1'b1, in_byte, 1'b0, st.val);
            phase_next = PH_DONE;
          end else begin
            res = emit_item(in_byte);
          end
        end
        PH_CSIZE: begin
          crlf_next_v = (in_byte == CH_CR) ? 3'd1 : 3'd0;
          if (crlf == 3'd1 && in_byte == CH_LF) begin
            if (num.f.bad || num.f.ph < 2'd2) begin
              res        = fin_item(1'b0, 8'd0, 1'b1, st.val);
              res_v      = 1'b1;
              phase_next = PH_DONE;
            end else if (num.acc == '0) begin
              res        = fin_item(1'b0, 8'd0, 1'b0, st.val);
              res_v      = 1'b1;
              phase_next = PH_DONE;
            end else begin
              left_next  = num.acc;
              phase_next = PH_CDATA;
            end
          end else begin
            num_tmp  = (crlf == 3'd1) ? num_feed(num, CH_CR, 1'b1, 1'b0) : num;
            num_next = (in_byte != CH_CR) ? num_feed(num_tmp, in_byte, 1'b1, 1'b0) : num_tmp;
          end
        end
        PH_CDATA: begin
          left_next = left - 1'b1;
          if (left_next == '0) begin
            phase_next = PH_CSKIP;
            skip_next  = 2'd2;
          end
          res   = emit_item(in_byte);
          res_v = 1'b1;
        end
        PH_CSKIP: begin
          skip_tmp  = (skip != 2'd0) ? skip - 2'd1 : skip;
          skip_next = skip_tmp;
          if (skip_tmp == 2'd0) begin
            phase_next  = PH_CSIZE;
            crlf_next_v = 3'd0;
            num_next    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_STATUS;
      crlf    <= 3'd0;
      st      <= '0;
      npos    <= 5'd0;
      hits    <= 3'b011;
      num     <= '0;
      chpos   <= 3'd0;
      chunked <= 1'b0;
      clv     <= 1'b0;
      cl      <= '0;
      left    <= '0;
      skip    <= 2'd0;
    end else if (accept) begin
      phase   <= phase_next;
      crlf    <= crlf_next_v;
      st      <= st_next;
      npos    <= npos_next;
      hits    <= hits_next;
      num     <= num_next;
      chpos   <= chpos_next;
      chunked <= chunked_next;
      clv     <= clv_next;
      cl      <= cl_next;
      left    <= left_next;
      skip    <= skip_next;
    end
  end

endmodule

@@ src/hrd_queue.sv @@
// Short result queue between the parser front end and the output stage.
// Depends on hrd_pkg and the assertion macro header.
`include "http_response_deframer_top_assert.svh"
module hrd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hrd_pkg::result_t push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output hrd_pkg::result_t head
);
  import hrd_pkg::*;

  result_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign not_full  = (count != QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `HRD_ASSERT(a_no_overflow, push |-> (not_full || pop), "queue push while full")
  `HRD_ASSERT(a_no_underflow, pop |-> not_empty, "queue pop while empty")
  `HRD_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + 1'b1, "count slip")
  `HRD_ASSERT_RST(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule

@@ src/hrd_back.sv @@
// Back end: output register that drains the result queue onto the master stream.
// Depends on hrd_pkg.
module hrd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hrd_pkg::result_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_data,
  output logic             out_last,
  output logic [1:0]       out_user
);
  import hrd_pkg::*;

  result_t held;

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) held <= q_head;
  end

  assign out_data = {7'd0, held.status_code, held.body_byte};
  assign out_last = held.done_res;
  assign out_user = {held.malformed, held.has_byte};

endmodule

@@ src/http_response_deframer_top.sv @@
// Top level of the HTTP response deframer: parser front end, result queue, output stage.
// Depends on hrd_pkg, hrd_front, hrd_queue, hrd_back.
//
// channel   dir  tdata                          tuser                     tlast
// s_axis    in   [7:0] data_byte                [0] command               -
// m_axis    out  [7:0] body_byte,[24:8] status  [0] has_byte,[1] malformed done_res
//
// One byte per cycle sustained while the result queue is not full.
// A result reaches m_axis through the queue write, then the output register.
// Reset is synchronous; it empties the queue and puts the parser in the status line phase.
// s_axis_tready drops only when the four-entry result queue is full.
module http_response_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] body_byte, [24:8] status_code, rest zero
  output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] malformed
  output logic        m_axis_tlast    // done_res
);
  import hrd_pkg::*;

  logic    push, q_ready, q_valid, pop;
  result_t push_data, q_head;

  hrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .q_ready   (q_ready),
    .push      (push),
    .push_data (push_data)
  );

  hrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_ready),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  hrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_user  (m_axis_tuser)
  );

endmodule

@@ test/http_response_deframer_checker.sv @@
// Checker for the HTTP response deframer: predicts every result from the input items and
// compares the results that are accepted. Depends on hrd_pkg (phase_t, result_t).
module http_response_deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending
);
  import hrd_pkg::*;

  localparam longint unsigned LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam string CL_TEXT = "content-length";
  localparam string TE_TEXT = "transfer-encoding";
  localparam string CH_TEXT = "chunked";

  phase_t          phase;
  logic [2:0]      crlf;
  int              stat_val;
  logic [1:0]      stat_cnt;
  logic            stat_bad;
  int              name_pos;
  logic [2:0]      name_hits;   // [0] may be length, [1] may be encoding, [2] in value
  logic [1:0]      sc_ph;
  logic            sc_neg;
  logic            sc_bad;
  int              word_pos;
  logic            chunked;
  longint unsigned len_acc;
  longint          clen;
  longint unsigned left;
  longint unsigned csize;
  int              skip;

  result_t         expect_q[$];

  assign pending = expect_q.size();

  function automatic logic ws(input logic [7:0] b);
    return b == CH_SP || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [2:0] crlf_step(input logic [2:0] m, input logic [7:0] b);
    if (b == CH_CR) return (m == 3'd2) ? 3'd3 : 3'd1;
    if (b == CH_LF) return (m == 3'd1) ? 3'd2 : ((m == 3'd3) ? 3'd4 : 3'd0);
    return 3'd0;
  endfunction

  task automatic scan_num(inout longint unsigned acc, input logic [7:0] b, input int base,
                          input logic signs);
    int d;
    if (sc_bad) return;
    if (b >= "0" && b <= "9") d = b - "0";
    else if (b >= "a" && b <= "f") d = b - "a" + 10;
    else if (b >= "A" && b <= "F") d = b - "A" + 10;
    else d = 16;
    if (ws(b)) begin
      if (sc_ph == 2'd1) sc_bad = 1'b1;
      else if (sc_ph == 2'd2) sc_ph = 2'd3;
    end else if (signs && sc_ph == 2'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
      if (b == CH_MINUS) sc_neg = 1'b1;
      sc_ph = 2'd1;
    end else if (d >= base || sc_ph == 2'd3) begin
      sc_bad = 1'b1;
    end else begin
      if (acc > (LEN_LIMIT - longint'(d)) / base) sc_bad = 1'b1;
      else acc = acc * base + d;
      sc_ph = 2'd2;
    end
  endtask

  task automatic status_char(input logic [7:0] b);
    int v;
    if (b == CH_SP) begin
      if (stat_cnt < 2'd2) stat_cnt++;
    end else if (stat_cnt == 2'd1) begin
      if (b >= "0" && b <= "9") begin
        v = stat_val * 10 + (b - "0");
        stat_val = (v > 65535) ? 65535 : v;
      end else begin
        stat_bad = 1'b1;
      end
    end
  endtask

  task automatic new_line();
    name_pos = 0;
    name_hits = 3'b011;
    sc_ph = 2'd0;
    sc_neg = 1'b0;
    sc_bad = 1'b0;
    len_acc = 0;
    word_pos = 0;
  endtask

  task automatic clear_all();
    phase = PH_STATUS;
    crlf = 3'd0;
    stat_val = 0;
    stat_cnt = 2'd0;
    stat_bad = 1'b0;
    new_line();
    chunked = 1'b0;
    clen = -1;
    left = 0;
    csize = 0;
    skip = 0;
  endtask

  task automatic header_char(input logic [7:0] b);
    logic [7:0] c;
    c = lower(b);
    if (b == CH_LF) begin
      if (name_hits[2]) begin
        if (name_hits[0]) begin
          if (sc_bad || sc_ph < 2'd2) clen = 0;
          else if (sc_neg && len_acc != 0) clen = -1;
          else clen = longint'(len_acc);
        end else if (name_hits[1] && word_pos == CH_LEN) begin
          chunked = 1'b1;
        end
      end
      new_line();
      return;
    end
    if (!name_hits[2]) begin
      if (b == CH_COLON || ws(b)) begin
        if (b == CH_COLON || name_pos > 0) begin
          if (name_pos != CL_LEN) name_hits[0] = 1'b0;
          if (name_pos != TE_LEN) name_hits[1] = 1'b0;
        end
        if (b == CH_COLON) name_hits[2] = 1'b1;
      end else begin
        if (name_pos >= CL_LEN || c != CL_TEXT[name_pos]) name_hits[0] = 1'b0;
        if (name_pos >= TE_LEN || c != TE_TEXT[name_pos]) name_hits[1] = 1'b0;
        if (name_pos < 31) name_pos++;
      end
      return;
    end
    scan_num(len_acc, b, 10, 1'b1);
    if (word_pos < CH_LEN) begin
      if (c == CH_TEXT[word_pos]) word_pos++;
      else word_pos = (c == CH_C) ? 1 : 0;
    end
  endtask

  task automatic chunk_line();
    phase = PH_CSIZE;
    crlf = 3'd0;
    sc_ph = 2'd0;
    sc_neg = 1'b0;
    sc_bad = 1'b0;
    csize = 0;
  endtask

  function automatic result_t completion(input logic has, input logic [7:0] b,
                                         input logic bad);
    result_t r;
    r.has_byte = has;
    r.body_byte = has ? b : 8'd0;
    r.done_res = 1'b1;
    r.status_code = bad ? 17'h1ffff : 17'(stat_val);
    r.malformed = bad;
    return r;
  endfunction

  // one input item -> zero or one expected result
  task automatic predict(input logic cmd, input logic [7:0] b, output logic got,
                         output result_t r);
    logic [2:0] prev;
    got = 1'b0;
    r = '0;
    if (cmd) begin
      clear_all();
      return;
    end
    case (phase)
      PH_STATUS: begin
        prev = crlf;
        crlf = crlf_step(crlf, b);
        if (prev == 3'd1 && b == CH_LF) begin
          if (stat_cnt == 2'd0) stat_val = -1;
          else if (stat_bad) stat_val = 0;
          phase = PH_HDR0;
        end else begin
          if (prev == 3'd1) status_char(CH_CR);
          if (b != CH_CR) status_char(b);
        end
      end
      PH_HDR0, PH_HDR1, PH_HDR: begin
        crlf = crlf_step(crlf, b);
        if (phase == PH_HDR1 && b == CH_LF) begin
          got = 1'b1;
          r = completion(1'b0, 8'd0, 1'b1);
          phase = PH_DONE;
        end else begin
          phase = (phase == PH_HDR0 && b == CH_CR) ? PH_HDR1 : PH_HDR;
          header_char(b);
          if (crlf == 3'd4) begin
            if (chunked) begin
              chunk_line();
            end else if (clen > 0) begin
              left = longint'(clen);
              phase = PH_BODY;
            end else begin
              got = 1'b1;
              r = completion(1'b0, 8'd0, 1'b0);
              phase = PH_DONE;
            end
          end
        end
      end
      PH_BODY: begin
        left--;
        got = 1'b1;
        if (left == 0) begin
          r = completion(1'b1, b, 1'b0);
          phase = PH_DONE;
        end else begin
          r.has_byte = 1'b1;
          r.body_byte = b;
        end
      end
      PH_CSIZE: begin
        prev = crlf;
        crlf = (b == CH_CR) ? 3'd1 : 3'd0;
        if (prev == 3'd1 && b == CH_LF) begin
          if (sc_bad || sc_ph < 2'd2) begin
            got = 1'b1;
            r = completion(1'b0, 8'd0, 1'b1);
            phase = PH_DONE;
          end else if (csize == 0) begin
            got = 1'b1;
            r = completion(1'b0, 8'd0, 1'b0);
            phase = PH_DONE;
          end else begin
            left = csize;
            phase = PH_CDATA;
          end
        end else begin
          if (prev == 3'd1) scan_num(csize, CH_CR, 16, 1'b0);
          if (b != CH_CR) scan_num(csize, b, 16, 1'b0);
        end
      end
      PH_CDATA: begin
        left--;
        if (left == 0) begin
          phase = PH_CSKIP;
          skip = 2;
        end
        got = 1'b1;
        r.has_byte = 1'b1;
        r.body_byte = b;
      end
      PH_CSKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) chunk_line();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic    got;
    result_t r;
    result_t act;
    result_t want;
    if (rst) begin
      clear_all();
      expect_q.delete();
      errors <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict(s_axis_tuser, s_axis_tdata, got, r);
        if (got) expect_q.insert(expect_q.size(), r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act.has_byte = m_axis_tuser[0];
        act.body_byte = m_axis_tdata[7:0];
        act.done_res = m_axis_tlast;
        act.status_code = m_axis_tdata[24:8];
        act.malformed = m_axis_tuser[1];
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected item has=%0d byte=%02h done=%0d status=%05h bad=%0d",
                   $time, act.has_byte, act.body_byte, act.done_res, act.status_code,
                   act.malformed);
          errors <= errors + 1;
        end else begin
          want = expect_q[0];
          expect_q.delete(0);
          if (act.has_byte !== want.has_byte || act.body_byte !== want.body_byte ||
              act.done_res !== want.done_res || act.status_code !== want.status_code ||
              act.malformed !== want.malformed) begin
            $display("%0t: mismatch expected has=%0d byte=%02h done=%0d status=%05h bad=%0d",
                     $time, want.has_byte, want.body_byte, want.done_res, want.status_code,
                     want.malformed);
            $display("%0t:          actual   has=%0d byte=%02h done=%0d status=%05h bad=%0d",
                     $time, act.has_byte, act.body_byte, act.done_res, act.status_code,
                     act.malformed);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_http_response_deframer_top.sv @@
// Testbench top for the HTTP response deframer: clock, reset, response stimulus, receiver
// stalls and verdict. Depends on hrd_pkg, http_response_deframer_top and the checker.
module tb_http_response_deframer_top;
  import hrd_pkg::*;

  localparam int WATCHDOG = 3000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          errors;
  int          pending;

  logic        no_gaps = 1'b0;
  logic        hold_req = 1'b0;
  logic        holding = 1'b0;
  int          sent = 0;
  int          quiet = 0;
  logic [7:0]  tx_q[$];

  http_response_deframer_top dut (.*);

  http_response_deframer_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver readiness
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = !holding && (no_gaps || $urandom_range(99) >= 12);
    end
  end

  // long hold-off, asked for by the sender before a long body
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        holding = 1'b1;
        repeat (120) @(negedge clk);
        holding = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("tb_http_response_deframer_top: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 12) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tuser = cmd;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    sent++;
  endtask

  task automatic add(input string s);
    foreach (s[i]) tx_q.insert(tx_q.size(), s[i]);
  endtask

  // start a new response, then send whatever has been queued
  task automatic flush();
    logic [7:0] b;
    send_item(1'b1, 8'($urandom()));
    while (tx_q.size() > 0) begin
      b = tx_q[0];
      tx_q.delete(0);
      send_item(1'b0, b);
    end
  endtask

  function automatic string mixcase(input string s);
    string r;
    r = s;
    foreach (r[i])
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = r[i] - 8'd32;
    return r;
  endfunction

  task automatic add_bytes(input int n);
    repeat (n) tx_q.insert(tx_q.size(), 8'($urandom()));
  endtask

  task automatic rand_response();
    int n;
    int cl;
    logic is_ch;
    if ($urandom_range(99) < 12) begin
      // noise, heavy on line breaks, spaces and colons
      repeat ($urandom_range(30, 4)) begin
        case ($urandom_range(5))
          0: tx_q.insert(tx_q.size(), CH_CR);
          1: tx_q.insert(tx_q.size(), CH_LF);
          2: tx_q.insert(tx_q.size(), CH_SP);
          3: tx_q.insert(tx_q.size(), CH_COLON);
          default: tx_q.insert(tx_q.size(), 8'($urandom()));
        endcase
      end
      return;
    end
    case ($urandom_range(7))
      0: add("HTTP/1.1");
      1: add($sformatf("HTTP/1.1 %0d", $urandom_range(999999)));
      2: add("HTTP/1.1 2x0 Bad");
      default: add($sformatf("HTTP/1.1 %0d OK", $urandom_range(599, 100)));
    endcase
    add("\r\n");
    is_ch = 1'b0;
    cl = -1;
    n = $urandom_range(3);
    repeat (n) begin
      case ($urandom_range(5))
        0, 1: begin
          cl = $urandom_range(12);
          add({$urandom_range(1) ? string'(" ") : string'(""), mixcase("content-length"),
               $urandom_range(1) ? string'(" : ") : string'(":"), $sformatf("%0d", cl),
               "\r\n"});
        end
        2: begin
          is_ch = 1'b1;
          add({mixcase("Transfer-Encoding"), ": ",
               $urandom_range(1) ? string'("gzip, ") : string'(""),
               mixcase("chunked"), "\r\n"});
        end
        3: add({mixcase("content-length"), ": -", $sformatf("%0d", $urandom_range(3)),
                "\r\n"});
        default: add("X-Thing: value\r\n");
      endcase
    end
    add("\r\n");
    if (is_ch) begin
      repeat ($urandom_range(3, 1)) begin
        n = $urandom_range(10, 1);
        add({$urandom_range(1) ? mixcase($sformatf("%0h", n)) : $sformatf(" %0h ", n),
             "\r\n"});
        add_bytes(n);
        add_bytes(2);
      end
      add("0\r\n\r\n");
    end else if (cl > 0) begin
      add_bytes(cl);
    end
    if ($urandom_range(3) == 0) add_bytes($urandom_range(4, 1));
    // occasional corruption of one byte
    if ($urandom_range(9) == 0) tx_q[$urandom_range(tx_q.size() - 1)] = 8'($urandom());
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tuser = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: saturation, non-numeric, missing status word, blank line right after
    // status, bad chunk sizes, huge chunk size, zero and negative lengths, late bytes
    add("HTTP/1.1 99999 OK\r\ncontent-length: 3\r\n\r\n"); add_bytes(3);
    add("\xff\x00\x80"); flush();
    // no idling on either side for a long stretch
    no_gaps = 1'b1;
    add("HTTP/1.1 +20\r\nX: y\r\n\r\n"); flush();
    add("HTTP/1.1\r\nA: b\r\n\r\n"); flush();
    add("HTTP/1.1 200 OK\r\n\r\n"); flush();
    add("HTTP/1.1 200 OK\r\nTRANSFER-ENCODING: Chunked\r\n\r\n0x5\r\n"); flush();
    add("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n100000000\r\n"); flush();
    add("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n\r\n"); flush();
    add("HTTP/1.1 201 OK\r\nTransfer-Encoding: chunked\r\n\r\nFfFfFfFf;x\r\n"); flush();
    add("HTTP/1.1 204 OK\r\n Content-Length : 0 \r\n\r\nzz"); flush();
    add("HTTP/1.1 200 OK\r\ncontent-length: 99999999999\r\n\r\n"); flush();
    add("HTTP/1.1 404 NF\r\nContent-Length: -7\r\n\r\nab"); flush();
    add("HTTP/1.1 200 OK\r\nContent-Length: 2\r\nTransfer-Encoding: chunked\r\n\r\n");
    add("a\r\n"); add_bytes(10); add("\r\n0\r\n\r\n"); flush();
    no_gaps = 1'b0;

    // receiver holds off while a long body streams in
    add("HTTP/1.1 200 OK\r\nContent-Length: 60\r\n\r\n"); add_bytes(60);
    hold_req = 1'b1;
    flush();

    // sender waits for every expected result
    while (pending != 0) @(negedge clk);

    while (sent < 690) begin
      rand_response();
      flush();
    end

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_http_response_deframer_top: PASS");
    end else begin
      $display("tb_http_response_deframer_top: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/hrd_pkg.sv
src/hrd_front.sv
src/hrd_queue.sv
src/hrd_back.sv
src/http_response_deframer_top.sv
test/http_response_deframer_checker.sv
test/tb_http_response_deframer_top.sv
